// File: rtl/lbcd_pkg.sv
// Shared types, constants and helpers for the LRU block cache directory.
`default_nettype none
package lbcd_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int KEY_BITS   = 16;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = SLOT_W + 1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [1:0]          req_t;

  localparam req_t REQ_LOOKUP     = 2'd0;
  localparam req_t REQ_FILL       = 2'd1;
  localparam req_t REQ_INVALIDATE = 2'd2;
  // Unused code: no state change, neutral result
  localparam req_t REQ_RESERVED   = 2'd3;

  localparam key_t EMPTY_KEY = '1;
  localparam cnt_t SLOTS_CNT = cnt_t'(SLOT_COUNT);

  // One directory row holds every slot
  typedef struct packed {
    key_t  [SLOT_COUNT-1:0] key;
    logic  [SLOT_COUNT-1:0] valid;
    slot_t [SLOT_COUNT-1:0] rank;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Row contents after reset: all empty, rank equals slot number
  function automatic row_t reset_row();
    row_t r;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      r.key[i]   = EMPTY_KEY;
      r.valid[i] = 1'b0;
      r.rank[i]  = slot_t'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lbcd_req_if.sv
// Request channel interface of the directory.
`default_nettype none
interface lbcd_req_if import lbcd_pkg::*; ();
  logic  valid;
  logic  ready;
  req_t  req_type;
  key_t  block_key;
  slot_t target_slot;
  logic  fill_ok;

  modport source (output valid, req_type, block_key, target_slot, fill_ok, input ready);
  modport sink   (input valid, req_type, block_key, target_slot, fill_ok, output ready);
endinterface
`default_nettype wire

// File: rtl/lbcd_rsp_if.sv
// Result channel interface of the directory.
`default_nettype none
interface lbcd_rsp_if import lbcd_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  hit;
  slot_t slot;
  logic  evicted_valid;
  key_t  evicted_key;

  modport source (output valid, hit, slot, evicted_valid, evicted_key, input ready);
  modport sink   (input valid, hit, slot, evicted_valid, evicted_key, output ready);
endinterface
`default_nettype wire

// File: rtl/lbcd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module lbcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/lru_block_cache_directory_top.sv
// Fully associative LRU cache directory: the whole directory lives in one wide
// row of a synchronous RAM. A request reads the row in S_IDLE, then in S_EXEC
// matches all slots, updates the recency ranks and writes the row back, so a
// new request is taken only after the last one has written its row. The result
// sits in an output register, so the next request may enter while it waits. A
// write of entries_in_use that shrinks the active set triggers one extra
// read-write pass that empties the dropped slots before the next request is
// taken. After reset the row reads as all empty with rank equal to slot number.
`default_nettype none
module lru_block_cache_directory_top import lbcd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lbcd_req_if.sink         in_req,
  lbcd_rsp_if.source       out_rsp,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   row_init_r;
  cnt_t   n_r;
  logic   pend_r;
  cnt_t   thr_r;
  logic   shrink_r;
  req_t   req_r;
  key_t   key_r;
  slot_t  tgt_r;
  logic   ok_r;

  logic   out_valid_r;
  logic   out_hit_r;
  slot_t  out_slot_r;
  logic   out_ev_valid_r;
  key_t   out_ev_key_r;

  logic             rd_en, wr_en;
  logic [ROW_W-1:0] rd_data;
  row_t             cur, row_nxt;

  logic   res_hit, res_ev_valid;
  slot_t  res_slot;
  key_t   res_ev_key;
  logic   out_free;
  cnt_t   cfg_sat;

  lbcd_ram #(.WIDTH(ROW_W), .DEPTH(1)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(1'b0),
    .wr_data(row_nxt),
    .rd_en  (rd_en),
    .rd_addr(1'b0),
    .rd_data(rd_data)
  );

  assign cur      = row_init_r ? row_t'(rd_data) : reset_row();
  assign out_free = !out_valid_r || out_rsp.ready;

  assign in_req.ready = (state_r == S_IDLE) && !pend_r;
  assign rd_en        = (state_r == S_IDLE) && (pend_r || in_req.valid);
  assign wr_en        = (state_r == S_EXEC) && (shrink_r || out_free);

  // Saturate the register write into 1..SLOT_COUNT
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_sat = cnt_t'(1);
    end else if (cnt_t'(cfg_wdata) > SLOTS_CNT) begin
      cfg_sat = SLOTS_CNT;
    end else begin
      cfg_sat = cnt_t'(cfg_wdata);
    end
  end

  // Row update and result for the item in flight
  always_comb begin
    logic [SLOT_COUNT-1:0] match, by_rank, lowest;
    logic [SLOT_COUNT-1:0] rank_oh [SLOT_COUNT];
    slot_t s;
    slot_t r;
    cnt_t  last;
    row_nxt      = cur;
    res_hit      = 1'b0;
    res_slot     = '0;
    res_ev_valid = 1'b0;
    res_ev_key   = EMPTY_KEY;
    by_rank      = '0;
    s            = '0;
    r            = '0;
    last         = n_r - cnt_t'(1);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      rank_oh[i] = SLOT_COUNT'(1) << cur.rank[i];
      match[i]   = cur.valid[i] && (cnt_t'(cur.rank[i]) < n_r) && (cur.key[i] == key_r);
      by_rank    = by_rank | (match[i] ? rank_oh[i] : '0);
    end
    lowest = by_rank & (~by_rank + SLOT_COUNT'(1));
    if (shrink_r) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cnt_t'(cur.rank[i]) >= thr_r) begin
          row_nxt.key[i]   = EMPTY_KEY;
          row_nxt.valid[i] = 1'b0;
        end
      end
    end else begin
      case (req_r)
        REQ_LOOKUP: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (match[i] && ((rank_oh[i] & lowest) != '0)) begin
              s = s | slot_t'(i);
            end
          end
          if (by_rank != '0) begin
            res_hit  = 1'b1;
            res_slot = s;
            r        = cur.rank[s];
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (cur.rank[i] < r) row_nxt.rank[i] = cur.rank[i] + slot_t'(1);
            end
            row_nxt.rank[s] = '0;
          end
        end
        REQ_FILL: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (cnt_t'(cur.rank[i]) == last) s = s | slot_t'(i);
          end
          res_slot = s;
          if (cur.valid[s]) begin
            res_ev_valid = 1'b1;
            res_ev_key   = cur.key[s];
          end
          r = cur.rank[s];
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (cur.rank[i] < r) row_nxt.rank[i] = cur.rank[i] + slot_t'(1);
          end
          row_nxt.rank[s] = '0;
          if (ok_r && (key_r != EMPTY_KEY)) begin
            row_nxt.key[s]   = key_r;
            row_nxt.valid[s] = 1'b1;
          end else begin
            row_nxt.key[s]   = EMPTY_KEY;
            row_nxt.valid[s] = 1'b0;
          end
        end
        REQ_INVALIDATE: begin
          res_slot = tgt_r;
          r        = cur.rank[tgt_r];
          if (cnt_t'(r) < n_r) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if ((cur.rank[i] > r) && (cnt_t'(cur.rank[i]) < n_r)) begin
                row_nxt.rank[i] = cur.rank[i] - slot_t'(1);
              end
            end
            row_nxt.rank[tgt_r]  = slot_t'(last);
            row_nxt.key[tgt_r]   = EMPTY_KEY;
            row_nxt.valid[tgt_r] = 1'b0;
          end
        end
        default: begin
          res_slot = '0;
        end
      endcase
    end
  end

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_init_r  <= 1'b0;
      n_r         <= SLOTS_CNT;
      pend_r      <= 1'b0;
      thr_r       <= SLOTS_CNT;
      shrink_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drain the result beat unless a new one replaces it this cycle
      if (out_valid_r && out_rsp.ready && !(wr_en && !shrink_r)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pend_r) begin
            shrink_r <= 1'b1;
            state_r  <= S_EXEC;
          end else if (in_req.valid) begin
            shrink_r <= 1'b0;
            req_r    <= in_req.req_type;
            key_r    <= in_req.block_key;
            tgt_r    <= in_req.target_slot;
            ok_r     <= in_req.fill_ok;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (wr_en) begin
            row_init_r <= 1'b1;
            state_r    <= S_IDLE;
            if (shrink_r) begin
              pend_r <= 1'b0;
            end else begin
              out_valid_r    <= 1'b1;
              out_hit_r      <= res_hit;
              out_slot_r     <= res_slot;
              out_ev_valid_r <= res_ev_valid;
              out_ev_key_r   <= res_ev_key;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Register write; a shrink schedules an emptying pass
      if (cfg_we) begin
        n_r <= cfg_sat;
        if (cfg_sat < n_r) begin
          pend_r <= 1'b1;
          thr_r  <= (pend_r && (thr_r < cfg_sat)) ? thr_r : cfg_sat;
        end
      end
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.hit           = out_hit_r;
  assign out_rsp.slot          = out_slot_r;
  assign out_rsp.evicted_valid = out_ev_valid_r;
  assign out_rsp.evicted_key   = out_ev_key_r;

  // Checks
  a_acc_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == S_EXEC && !shrink_r))
    else $error("accepted beat did not start execution");
  a_wr_exec: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_EXEC))
    else $error("row written outside execute");
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r != '0) && (n_r <= SLOTS_CNT))
    else $error("active slot count out of range");
  a_pend_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && pend_r) |=> (state_r == S_EXEC && shrink_r))
    else $error("pending shrink not serviced");

endmodule
`default_nettype wire

// File: test/lru_block_cache_directory_top_test.sv
// Self-checking testbench for the LRU block cache directory top level.
module lru_block_cache_directory_top_test;
  import lbcd_pkg::*;

  typedef struct packed {
    req_t  req_type;
    key_t  block_key;
    slot_t target_slot;
    logic  fill_ok;
  } dir_req_t;

  typedef struct packed {
    logic  hit;
    slot_t slot;
    logic  evicted_valid;
    key_t  evicted_key;
  } dir_rsp_t;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = 7'd0;

  lbcd_req_if in_req ();
  lbcd_rsp_if out_rsp ();

  lru_block_cache_directory_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predicted directory contents
  key_t  dir_key [SLOT_COUNT];
  logic  dir_valid [SLOT_COUNT];
  int    dir_rank [SLOT_COUNT];
  int    active_slots;

  dir_req_t pending_reqs[$];
  dir_rsp_t expected_rsps[$];
  int mismatches = 0;
  int beats_in = 0, beats_out = 0;
  int send_idle_pct = 21, recv_idle_pct = 68;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic dir_reset();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      dir_key[i] = EMPTY_KEY;
      dir_valid[i] = 1'b0;
      dir_rank[i] = i;
    end
    active_slots = SLOT_COUNT;
  endtask

  task automatic dir_resize(int value);
    int n;
    n = (value < 1) ? 1 : (value > SLOT_COUNT ? SLOT_COUNT : value);
    if (n < active_slots)
      for (int i = 0; i < SLOT_COUNT; i++)
        if (dir_rank[i] >= n) begin
          dir_key[i] = EMPTY_KEY;
          dir_valid[i] = 1'b0;
        end
    active_slots = n;
  endtask

  function automatic void promote(int s);
    int r;
    r = dir_rank[s];
    for (int i = 0; i < SLOT_COUNT; i++)
      if (dir_rank[i] < r) dir_rank[i]++;
    dir_rank[s] = 0;
  endfunction

  // Computes the result of one request and updates the directory
  function automatic dir_rsp_t dir_access(dir_req_t rq);
    dir_rsp_t rs;
    int best, best_rank, victim, r;
    rs = '{hit: 1'b0, slot: '0, evicted_valid: 1'b0, evicted_key: EMPTY_KEY};
    case (rq.req_type)
      REQ_LOOKUP: begin
        best = -1;
        best_rank = SLOT_COUNT;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (dir_valid[i] && dir_rank[i] < active_slots && dir_key[i] == rq.block_key &&
              dir_rank[i] < best_rank) begin
            best = i;
            best_rank = dir_rank[i];
          end
        if (best >= 0) begin
          promote(best);
          rs.hit = 1'b1;
          rs.slot = slot_t'(best);
        end
      end
      REQ_FILL: begin
        victim = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (dir_rank[i] == active_slots - 1) victim = i;
        if (dir_valid[victim]) begin
          rs.evicted_valid = 1'b1;
          rs.evicted_key = dir_key[victim];
        end
        promote(victim);
        if (rq.fill_ok && rq.block_key != EMPTY_KEY) begin
          dir_key[victim] = rq.block_key;
          dir_valid[victim] = 1'b1;
        end else begin
          dir_key[victim] = EMPTY_KEY;
          dir_valid[victim] = 1'b0;
        end
        rs.slot = slot_t'(victim);
      end
      REQ_INVALIDATE: begin
        rs.slot = rq.target_slot;
        if (dir_rank[rq.target_slot] < active_slots) begin
          dir_key[rq.target_slot] = EMPTY_KEY;
          dir_valid[rq.target_slot] = 1'b0;
          r = dir_rank[rq.target_slot];
          for (int i = 0; i < SLOT_COUNT; i++)
            if (dir_rank[i] > r && dir_rank[i] < active_slots) dir_rank[i]--;
          dir_rank[rq.target_slot] = active_slots - 1;
        end
      end
      default: ;
    endcase
    return rs;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
    mismatches++;
  endtask

  // Driver: offers queued requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        expected_rsps.push_back(dir_access(pending_reqs.pop_front()));
        beats_in++;
      end
      if ((!in_req.valid || in_req.ready)) begin
        if (pending_reqs.size() > 0 &&
            !(in_req.valid && in_req.ready && pending_reqs.size() == 0) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_req.valid <= 1'b1;
          {in_req.req_type, in_req.block_key, in_req.target_slot, in_req.fill_ok}
            <= pending_reqs[0];
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result beats and checks them in order
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        beats_out++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          dir_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_rsp.hit !== e.hit) report_mismatch("hit", out_rsp.hit, e.hit);
          if (out_rsp.slot !== e.slot) report_mismatch("slot", out_rsp.slot, e.slot);
          if (out_rsp.evicted_valid !== e.evicted_valid)
            report_mismatch("evicted_valid", out_rsp.evicted_valid, e.evicted_valid);
          if (out_rsp.evicted_key !== e.evicted_key)
            report_mismatch("evicted_key", out_rsp.evicted_key, e.evicted_key);
        end
      end
      // Long hold-off, counted here
      if (hold_req) hold_cnt <= HOLD_CYCLES;
      else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
      out_rsp.ready <= !hold_req && (hold_cnt == 0) &&
                       ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        timed_out = 1'b1;
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic dir_req_t rand_req(int key_span);
    dir_req_t rq;
    int k;
    k = $urandom_range(99);
    rq.req_type = (k < 45) ? REQ_LOOKUP : (k < 85) ? REQ_FILL :
                  (k < 98) ? REQ_INVALIDATE : REQ_RESERVED;
    rq.block_key = (k % 7 == 0) ? key_t'($urandom()) : key_t'($urandom_range(key_span));
    if ($urandom_range(49) == 0) rq.block_key = EMPTY_KEY;
    rq.target_slot = slot_t'($urandom());
    rq.fill_ok = ($urandom_range(9) != 0);
    return rq;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || in_req.valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_entries(int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= 7'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_resize(value & 7'h7f);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(int count, int key_span);
    for (int i = 0; i < count; i++) pending_reqs.push_back(rand_req(key_span));
  endtask

  initial begin
    int sizes[6] = '{1, 64, 0, 100, 3, 17};
    in_req.valid = 1'b0;
    in_req.req_type = REQ_LOOKUP;
    in_req.block_key = '0;
    in_req.target_slot = '0;
    in_req.fill_ok = 1'b0;
    out_rsp.ready = 1'b0;
    dir_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every request type, duplicates, empty key, type 3
    pending_reqs.push_back('{REQ_LOOKUP, 16'd0, 6'd0, 1'b0});
    pending_reqs.push_back('{REQ_FILL, 16'd0, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_FILL, 16'hfffe, 6'd63, 1'b1});
    pending_reqs.push_back('{REQ_FILL, 16'hfffe, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_LOOKUP, 16'hfffe, 6'd0, 1'b0});
    pending_reqs.push_back('{REQ_FILL, EMPTY_KEY, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_FILL, 16'h1234, 6'd0, 1'b0});
    pending_reqs.push_back('{REQ_LOOKUP, EMPTY_KEY, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_LOOKUP, 16'd0, 6'd0, 1'b0});
    pending_reqs.push_back('{REQ_INVALIDATE, 16'd0, 6'd0, 1'b0});
    pending_reqs.push_back('{REQ_INVALIDATE, 16'hffff, 6'd63, 1'b1});
    pending_reqs.push_back('{REQ_RESERVED, 16'hffff, 6'd63, 1'b1});
    pending_reqs.push_back('{REQ_LOOKUP, 16'd0, 6'd0, 1'b0});
    drain();
    write_entries(2);
    pending_reqs.push_back('{REQ_FILL, 16'd7, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_FILL, 16'd8, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_FILL, 16'd9, 6'd0, 1'b1});
    pending_reqs.push_back('{REQ_INVALIDATE, 16'd0, 6'd40, 1'b0});
    pending_reqs.push_back('{REQ_LOOKUP, 16'd8, 6'd0, 1'b0});

    // Random phases over several sizes and idling patterns
    for (int p = 0; p < 6; p++) begin
      write_entries(sizes[p]);
      if (p < 2) begin send_idle_pct = 21; recv_idle_pct = 68; end
      else if (p < 4) begin send_idle_pct = 68; recv_idle_pct = 21; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (p == 4) begin
        // Receiver holds off long enough for the block to stall its input
        hold_req = 1'b1;
        run_random(30, 8);
        wait (hold_cnt != 0);
        hold_req = 1'b0;
        wait (hold_cnt == 0);
      end
      run_random(235, (p % 2) ? 40 : 300);
      // Sender pauses until all results are in
      while (pending_reqs.size() > 0 || in_req.valid) @(posedge clk);
      while (expected_rsps.size() > 0) @(posedge clk);
      run_random(5, 8);
    end
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests and checked %0d results over six slot counts",
             beats_in, beats_out);
    $display("including 1, 64 and out of range writes, with stalls on both sides");
    if (mismatches == 0 && expected_rsps.size() == 0 && !timed_out)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
